// ===== rtl/ecal_pkg.sv =====
// Package for the epoch-seconds to calendar converter: types, constants and the month table.
`timescale 1ns / 1ps
package ecal_pkg;

  localparam int SECONDS_WIDTH = 34;
  localparam int DAYS_W        = SECONDS_WIDTH - 16;   // 86400 exceeds 2**16
  localparam int TOD_W         = 17;                   // holds 0 .. 86399

  // A day is 2**7 * 675 seconds. The low seven bits of the seconds pass by, and the rest is
  // divided by 675 through a rounded-up reciprocal that is exact for every dividend of SECS_HI_W bits.
  localparam int SECS_LO_W   = 7;
  localparam int SECS_HI_W   = SECONDS_WIDTH - SECS_LO_W;
  localparam int DAY_ODD_W   = 10;
  localparam int RECIP_SHIFT = SECS_HI_W + DAY_ODD_W;
  localparam int RECIP_W     = SECS_HI_W + 1;
  localparam int PROD_W      = SECS_HI_W + RECIP_W;

  localparam logic [DAY_ODD_W-1:0] DAY_ODD   = DAY_ODD_W'(675);
  localparam longint unsigned      RECIP_VAL = ((64'd1 << RECIP_SHIFT) + 64'd674) / 64'd675;
  localparam logic [RECIP_W-1:0]   DAY_RECIP = RECIP_W'(RECIP_VAL);

  localparam logic [TOD_W-1:0] SECS_PER_HOUR = TOD_W'(3600);
  localparam logic [TOD_W-1:0] SECS_PER_MIN  = TOD_W'(60);

  localparam int EPOCH_YEAR = 1970;
  localparam logic [11:0] EPOCH_YEAR_12 = 12'(EPOCH_YEAR);
  localparam logic [1:0]  EPOCH_MOD4    = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0]  EPOCH_MOD100  = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0]  EPOCH_MOD400  = 9'(EPOCH_YEAR % 400);

  localparam logic [23:0] MONTHS_COMMON = 24'hCEEFBB;
  localparam logic [23:0] MONTHS_LEAP   = 24'hDEEFBB;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [SECONDS_WIDTH-1:0] epoch_seconds;
    logic [19:0]              micro_seconds;
  } ecal_in_t;

  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [19:0] micro_out;
  } ecal_out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic year_step;
    logic month_step;
    logic hour_step;
    logic min_step;
    logic load_out;
  } ecal_cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_fits;
    logic month_fits;
    logic hour_fits;
    logic min_fits;
  } ecal_status_t;

  // Length of a month (1 to 12) from the packed two-bit table.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [23:0] tbl;
    logic [4:0]  sh;
    logic [1:0]  field;
    tbl   = leap ? MONTHS_LEAP : MONTHS_COMMON;
    sh    = 5'd24 - {month, 1'b0};
    field = tbl[sh +: 2];
    return 5'd28 + {3'd0, field};
  endfunction

endpackage

// ===== rtl/ecal_ctrl.sv =====
// Controller state machine that sequences the divide, year, month and time-of-day steps.
`timescale 1ns / 1ps
module ecal_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ecal_pkg::ecal_status_t status_i,
  output ecal_pkg::ecal_cmd_t   cmd_o
);
  import ecal_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_YEAR  = 7'b0000100,
    S_MONTH = 7'b0001000,
    S_HOUR  = 7'b0010000,
    S_MIN   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_YEAR;
        end
      end
      S_YEAR: begin
        if (status_i.year_fits) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (status_i.month_fits) begin
          state_d = S_HOUR;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_HOUR: begin
        if (status_i.hour_fits) begin
          state_d = S_MIN;
        end else begin
          cmd_o.hour_step = 1'b1;
        end
      end
      S_MIN: begin
        if (status_i.min_fits) begin
          state_d = S_DONE;
        end else begin
          cmd_o.min_step = 1'b1;
        end
      end
      S_DONE: begin
        // The finished item moves into the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DIV)
    else $error("accepted item did not start the division");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_o.load_out)
    else $error("output register overwritten while stalled");

  a_div_to_year : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && status_i.div_last |=> state_q == S_YEAR)
    else $error("division did not hand over to the year walk");

endmodule

// ===== rtl/ecal_dpath.sv =====
// Datapath: reciprocal divide by 86400, year and month walks, time-of-day split, output register.
`timescale 1ns / 1ps
module ecal_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ecal_pkg::ecal_in_t     in_data_i,
  input  ecal_pkg::ecal_cmd_t    cmd_i,
  output ecal_pkg::ecal_status_t status_o,
  output ecal_pkg::ecal_out_t    out_data_o
);
  import ecal_pkg::*;

  logic [SECONDS_WIDTH-1:0] secs_q, secs_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic                     div_phase_q, div_phase_d;
  logic [TOD_W-1:0]         rem_q, rem_d;
  logic [DAYS_W-1:0]        days_q, days_d;
  logic [11:0]              year_q, year_d;
  logic [1:0]               mod4_q, mod4_d;
  logic [6:0]               mod100_q, mod100_d;
  logic [8:0]               mod400_q, mod400_d;
  logic [3:0]               month_q, month_d;
  logic [4:0]               hour_q, hour_d;
  logic [5:0]               min_q, min_d;
  logic [19:0]              micro_q, micro_d;
  ecal_out_t                out_q, out_d;

  logic [SECS_HI_W-1:0]          secs_hi;
  logic [DAYS_W-1:0]             quot;
  logic [DAYS_W+DAY_ODD_W-1:0]   quot_back;
  logic [SECS_HI_W-1:0]          day_rest;
  logic                          leap;
  logic [8:0]                    ylen;
  logic [4:0]                    mlen;

  // The first divide step registers the reciprocal product; the second takes the quotient from
  // its top bits and rebuilds the remainder from the divide's rest and the low seven bits.
  assign secs_hi   = secs_q[SECONDS_WIDTH-1 -: SECS_HI_W];
  assign quot      = prod_q[RECIP_SHIFT +: DAYS_W];
  assign quot_back = {{DAY_ODD_W{1'b0}}, quot} * {{DAYS_W{1'b0}}, DAY_ODD};
  assign day_rest  = secs_hi - SECS_HI_W'(quot_back);

  assign leap = (mod400_q == 9'd0) || ((mod100_q != 7'd0) && (mod4_q == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(leap, month_q);

  assign status_o.div_last   = div_phase_q;
  assign status_o.year_fits  = (days_q < DAYS_W'(ylen));
  assign status_o.month_fits = (month_q == MONTH_DEC) || (days_q < DAYS_W'(mlen));
  assign status_o.hour_fits  = (rem_q < SECS_PER_HOUR);
  assign status_o.min_fits   = (rem_q < SECS_PER_MIN);

  always_comb begin
    secs_d      = secs_q;
    prod_d      = prod_q;
    div_phase_d = div_phase_q;
    rem_d       = rem_q;
    days_d      = days_q;
    year_d      = year_q;
    mod4_d      = mod4_q;
    mod100_d    = mod100_q;
    mod400_d    = mod400_q;
    month_d     = month_q;
    hour_d      = hour_q;
    min_d       = min_q;
    micro_d     = micro_q;
    out_d       = out_q;

    if (cmd_i.load) begin
      secs_d      = in_data_i.epoch_seconds;
      micro_d     = in_data_i.micro_seconds;
      div_phase_d = 1'b0;
      rem_d       = '0;
      days_d      = '0;
      year_d      = EPOCH_YEAR_12;
      mod4_d      = EPOCH_MOD4;
      mod100_d    = EPOCH_MOD100;
      mod400_d    = EPOCH_MOD400;
      month_d     = MONTH_JAN;
      hour_d      = '0;
      min_d       = '0;
    end

    if (cmd_i.div_step) begin
      if (!div_phase_q) begin
        prod_d      = {{RECIP_W{1'b0}}, secs_hi} * {{SECS_HI_W{1'b0}}, DAY_RECIP};
        div_phase_d = 1'b1;
      end else begin
        days_d = quot;
        rem_d  = {day_rest[DAY_ODD_W-1:0], secs_q[SECS_LO_W-1:0]};
      end
    end

    if (cmd_i.year_step) begin
      days_d   = days_q - DAYS_W'(ylen);
      year_d   = year_q + 12'd1;
      mod4_d   = mod4_q + 2'd1;
      mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end

    if (cmd_i.month_step) begin
      days_d  = days_q - DAYS_W'(mlen);
      month_d = month_q + 4'd1;
    end

    if (cmd_i.hour_step) begin
      rem_d  = rem_q - SECS_PER_HOUR;
      hour_d = hour_q + 5'd1;
    end

    if (cmd_i.min_step) begin
      rem_d = rem_q - SECS_PER_MIN;
      min_d = min_q + 6'd1;
    end

    if (cmd_i.load_out) begin
      out_d.year_out   = year_q;
      out_d.month_out  = month_q;
      out_d.day_out    = days_q[4:0] + 5'd1;
      out_d.hour_out   = hour_q;
      out_d.minute_out = min_q;
      out_d.second_out = rem_q[5:0];
      out_d.micro_out  = micro_q;
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q      <= secs_d;
    prod_q      <= prod_d;
    div_phase_q <= div_phase_d;
    rem_q       <= rem_d;
    days_q      <= days_d;
    year_q      <= year_d;
    mod4_q      <= mod4_d;
    mod100_q    <= mod100_d;
    mod400_q    <= mod400_d;
    month_q     <= month_d;
    hour_q      <= hour_d;
    min_q       <= min_d;
    micro_q     <= micro_d;
    out_q       <= out_d;
  end

  assign out_data_o = out_q;

  a_date_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> month_q >= MONTH_JAN && month_q <= MONTH_DEC && days_q < DAYS_W'(31))
    else $error("month or day out of range at result load");

  a_year_step_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.year_step |-> !status_o.year_fits)
    else $error("year subtracted although the days fit in it");

  a_tod_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> hour_q < 5'd24 && min_q < 6'd60 && rem_q < SECS_PER_MIN)
    else $error("time of day out of range at result load");

endmodule

// ===== rtl/epoch_seconds_to_calendar_top.sv =====
// An accepted item passes through the reciprocal divide, then the year, month, hour and minute
// walks, stepping once per whole year, month, hour or minute past the epoch, and then waits
// in the done state until the output register is freed, after which out_valid_o rises.
// One item is in work at a time; in_ready_o rises at the edge that loads the result, so a new
// item is taken only once the last result is in the output register. The year walk takes most steps.
// Reset (rst_ni low, asynchronous) returns the controller to idle and empties the output register.
// Top level of the epoch-seconds to calendar converter.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ecal_pkg::ecal_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ecal_pkg::ecal_out_t out_data_o
);
  import ecal_pkg::*;

  ecal_cmd_t    cmd;
  ecal_status_t status;

  ecal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ecal_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
